/* hw/rtl/assert_macros.svh */
// Assertion macros for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define DAF_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define DAF_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* hw/rtl/dafmt_pkg.sv */
package dafmt_pkg;

   // Format selector codes.
   localparam logic [1:0] OP_SUPPRESSED = 2'd0;
   localparam logic [1:0] OP_THREE      = 2'd1;
   localparam logic [1:0] OP_FIXED      = 2'd2;
   // The fourth selector code has no format behind it.
   localparam logic [1:0] OP_UNUSED     = 2'd3;

   // ASCII codes that the formatter emits.
   localparam logic [7:0] CHAR_ZERO = 8'h30;
   localparam logic [7:0] CHAR_DOT  = 8'h2E;

   // Decimal place indexes: 0 is ten-thousands, 4 is units.
   localparam logic [2:0] PLACE_FIRST     = 3'd0;
   localparam logic [2:0] PLACE_THOUSANDS = 3'd1;
   localparam logic [2:0] PLACE_HUNDREDS  = 3'd2;
   localparam logic [2:0] PLACE_TENS      = 3'd3;
   localparam logic [2:0] PLACE_UNITS     = 3'd4;

   // Input item.
   typedef struct packed {
      logic [1:0]  operation;
      logic [15:0] value;
      logic [9:0]  fraction;
   } req_type;

   // Result item.
   typedef struct packed {
      logic [7:0] character;
      logic       last;
   } rsp_type;

   // Commands from the sequencer to the digit unit.
   typedef struct packed {
      logic       load;
      logic       step;
      logic [2:0] place;
      logic [1:0] shift;
   } unit_ctrl_type;

   // Place weight scaled by 1, 2, 4 or 8 for one bit of the digit.
   function automatic logic [16:0] scaled_weight(input logic [2:0] place,
                                                 input logic [1:0] shift);
      logic [16:0] base;
      case (place)
         PLACE_FIRST:     base = 17'd10000;
         PLACE_THOUSANDS: base = 17'd1000;
         PLACE_HUNDREDS:  base = 17'd100;
         PLACE_TENS:      base = 17'd10;
         default:         base = 17'd1;
      endcase
      return base << shift;
   endfunction

endpackage

/* hw/rtl/dafmt_digit_unit.sv */
module dafmt_digit_unit (
   input  logic                     clock,
   input  dafmt_pkg::unit_ctrl_type ctrl,
   input  logic [15:0]              load_value,
   output logic [3:0]               digit
);

   logic [15:0] rest_ff;
   logic [15:0] rest_in;
   logic [3:0]  digit_ff;
   logic [3:0]  digit_in;
   logic [17:0] diff;
   logic        fits;

   // One trial subtraction of the scaled place weight per step.
   assign diff = {2'b00, rest_ff} - {1'b0, dafmt_pkg::scaled_weight(ctrl.place, ctrl.shift)};
   assign fits = ~diff[17];

   // The digit builds up most significant bit first over four steps.
   always_comb begin
      rest_in  = rest_ff;
      digit_in = digit_ff;
      if (ctrl.load) begin
         rest_in = load_value;
      end else if (ctrl.step) begin
         rest_in  = fits ? diff[15:0] : rest_ff;
         digit_in = {digit_ff[2:0], fits};
      end
   end

   always_ff @(posedge clock) begin
      rest_ff  <= rest_in;
      digit_ff <= digit_in;
   end

   assign digit = digit_ff;

endmodule

/* hw/rtl/dafmt_sequencer.sv */
module dafmt_sequencer (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  dafmt_pkg::req_type       req_item,
   input  logic [3:0]               digit,
   output logic                     busy,
   output dafmt_pkg::unit_ctrl_type ctrl,
   output logic [15:0]              load_value,
   output logic                     rsp_strobe,
   output dafmt_pkg::rsp_type       rsp_item
);

   typedef enum logic [1:0] {S_IDLE, S_STEP, S_EMIT, S_DOT} state_type;

   state_type          state_ff, state_in;
   logic [1:0]         op_ff, op_in;
   logic [9:0]         fraction_ff, fraction_in;
   logic [2:0]         place_ff, place_in;
   logic [1:0]         shift_ff, shift_in;
   logic               phase_ff, phase_in;
   logic               started_ff, started_in;
   logic               strobe_ff, strobe_in;
   dafmt_pkg::rsp_type rsp_ff, rsp_in;
   logic               accept;
   logic               shown;
   logic               is_last;

   assign accept = start && (state_ff == S_IDLE) &&
                   (req_item.operation != dafmt_pkg::OP_UNUSED);

   // Places show from the first nonzero digit; padded fields show the last three.
   always_comb begin
      if (phase_ff || (op_ff == dafmt_pkg::OP_THREE)) begin
         shown = (place_ff >= dafmt_pkg::PLACE_HUNDREDS);
      end else begin
         shown = (digit != 4'd0) || started_ff || (place_ff == dafmt_pkg::PLACE_UNITS);
      end
      is_last = (place_ff == dafmt_pkg::PLACE_UNITS) &&
                (phase_ff || (op_ff != dafmt_pkg::OP_FIXED));
   end

   // Commands to the digit unit.
   always_comb begin
      ctrl.load  = accept || (state_ff == S_DOT);
      ctrl.step  = (state_ff == S_STEP);
      ctrl.place = place_ff;
      ctrl.shift = shift_ff;
      load_value = (state_ff == S_DOT) ? {6'd0, fraction_ff} : req_item.value;
   end

   // Next state and registered result.
   always_comb begin
      state_in    = state_ff;
      op_in       = op_ff;
      fraction_in = fraction_ff;
      place_in    = place_ff;
      shift_in    = shift_ff;
      phase_in    = phase_ff;
      started_in  = started_ff;
      strobe_in   = 1'b0;
      rsp_in      = rsp_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               op_in       = req_item.operation;
               fraction_in = req_item.fraction;
               place_in    = dafmt_pkg::PLACE_FIRST;
               shift_in    = 2'd3;
               phase_in    = 1'b0;
               started_in  = 1'b0;
               state_in    = S_STEP;
            end
         end
         S_STEP: begin
            shift_in = shift_ff - 2'd1;
            if (shift_ff == 2'd0) begin
               state_in = S_EMIT;
            end
         end
         S_EMIT: begin
            strobe_in           = shown;
            rsp_in.character    = dafmt_pkg::CHAR_ZERO + {4'd0, digit};
            rsp_in.last         = is_last;
            started_in          = started_ff || shown;
            shift_in            = 2'd3;
            if (place_ff == dafmt_pkg::PLACE_UNITS) begin
               if (!phase_ff && (op_ff == dafmt_pkg::OP_FIXED)) begin
                  state_in = S_DOT;
               end else begin
                  state_in = S_IDLE;
               end
            end else begin
               place_in = place_ff + 3'd1;
               state_in = S_STEP;
            end
         end
         S_DOT: begin
            // The fraction starts at the thousands place, which is never shown.
            strobe_in        = 1'b1;
            rsp_in.character = dafmt_pkg::CHAR_DOT;
            rsp_in.last      = 1'b0;
            phase_in         = 1'b1;
            place_in         = dafmt_pkg::PLACE_THOUSANDS;
            shift_in         = 2'd3;
            state_in         = S_STEP;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         strobe_ff <= strobe_in;
      end
      op_ff       <= op_in;
      fraction_ff <= fraction_in;
      place_ff    <= place_in;
      shift_ff    <= shift_in;
      phase_ff    <= phase_in;
      started_ff  <= started_in;
      rsp_ff      <= rsp_in;
   end

   assign busy       = (state_ff != S_IDLE);
   assign rsp_strobe = strobe_ff;
   assign rsp_item   = rsp_ff;

endmodule

/* hw/rtl/decimal_ascii_formatter_core.sv */
// Decimal ASCII formatter. A request is taken when start is high while busy
// is low; it prints value in decimal without leading zeros (operation 0),
// value modulo 1000 as three padded digits (operation 1), or value, a point
// and fraction modulo 1000 as three padded digits (operation 2). Operation 3
// is not taken and gives no results. Characters come out one item per
// rsp_strobe pulse, with last set on the final one; the receiver cannot
// stall them, so it must take every strobed item. Each decimal place takes
// four trial subtractions in the one shared subtractor of the digit unit,
// then an emit step. Busy therefore covers five places for operations 0
// and 1, and for operation 2 five integer places, the point and four
// fraction places. The final item shows on the ports in the
// first cycle after busy falls, and a new request may be taken then.
module decimal_ascii_formatter_core (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  dafmt_pkg::req_type req_item,
   output logic               busy,
   output logic               rsp_strobe,
   output dafmt_pkg::rsp_type rsp_item
);

   dafmt_pkg::unit_ctrl_type ctrl;
   logic [15:0]              load_value;
   logic [3:0]               digit;

   // Control sequencer and result register.
   dafmt_sequencer u_sequencer (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .req_item   (req_item),
      .digit      (digit),
      .busy       (busy),
      .ctrl       (ctrl),
      .load_value (load_value),
      .rsp_strobe (rsp_strobe),
      .rsp_item   (rsp_item)
   );

   // Shared compare-subtract unit that extracts one digit bit per cycle while the sequencer steps.
   dafmt_digit_unit u_digit_unit (
      .clock      (clock),
      .ctrl       (ctrl),
      .load_value (load_value),
      .digit      (digit)
   );

endmodule

/* hw/rtl/dafmt_checker.sv */
`include "assert_macros.svh"

module dafmt_checker (
   input logic               clock,
   input logic               reset,
   input logic               start,
   input dafmt_pkg::req_type req_item,
   input logic               busy,
   input logic               rsp_strobe,
   input dafmt_pkg::rsp_type rsp_item
);

   logic valid_char;
   logic real_req;
   logic final_item;

   // Every emitted character is a digit or the decimal point.
   assign valid_char = ((rsp_item.character >= dafmt_pkg::CHAR_ZERO) &&
                        (rsp_item.character <= dafmt_pkg::CHAR_ZERO + 8'd9)) ||
                       (rsp_item.character == dafmt_pkg::CHAR_DOT);

   // A taken request with a real format, and the final item of a request.
   assign real_req   = start && !busy && (req_item.operation != dafmt_pkg::OP_UNUSED);
   assign final_item = rsp_strobe && rsp_item.last;

   `DAF_ASSERT_IMPLY(a_char_valid, clock, reset, rsp_strobe, valid_char, "bad character")

   // A request with a real format keeps the block busy.
   `DAF_ASSERT_NEXT(a_accept_busy, clock, reset, real_req, busy, "request not taken")

   // The end of a request is marked by a final item as busy drops.
   `DAF_ASSERT_IMPLY(a_end_last, clock, reset, $fell(busy), final_item, "no final item")

   // Nothing follows the final item before a new request is taken.
   `DAF_ASSERT_NEXT(a_quiet_after_last, clock, reset, final_item, !rsp_strobe, "item after final")

endmodule

bind decimal_ascii_formatter_core dafmt_checker u_checker (.*);
